/* sv/lrfs_pkg.sv */
// Package for the line raster frame store.
// Holds field widths, action codes and the command descriptor passed from the front end
// to the back end. Depends on nothing.
package lrfs_pkg;

  // Field widths.
  localparam int unsigned COORD_W   = 11;
  localparam int unsigned DELTA_W   = 12;
  localparam int unsigned DIM_W     = 12;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COLOR_W   = 32;
  localparam int unsigned COUNT_W   = 13;

  // Default frame store geometry.
  localparam int unsigned MAX_WIDTH_DEF  = 512;
  localparam int unsigned MAX_HEIGHT_DEF = 512;

  // Command queue depth between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Reset value of both active area registers.
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 10'd512;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

  typedef enum logic [1:0] {
    ACT_PLOT  = 2'd0,
    ACT_LINE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Classified command. Plot and read use the major coordinate as x and
  // the minor coordinate as y.
  typedef struct packed {
    action_e              kind;
    logic                 x_major;
    logic                 step_neg;
    coord_t               maj_start;
    coord_t               maj_end;
    coord_t               min_start;
    logic [DELTA_W-1:0]   dmaj;
    logic [DELTA_W-1:0]   dmin;
    logic [COLOR_W-1:0]   color;
  } job_t;

endpackage

/* sv/lrfs_if.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on lrfs_pkg for the field widths.
interface lrfs_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        action;
  logic signed [lrfs_pkg::COORD_W-1:0] start_x;
  logic signed [lrfs_pkg::COORD_W-1:0] start_y;
  logic signed [lrfs_pkg::COORD_W-1:0] end_x;
  logic signed [lrfs_pkg::COORD_W-1:0] end_y;
  logic [lrfs_pkg::COLOR_W-1:0]      pixel_color;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, pixel_color,
    output ready
  );
endinterface

interface lrfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lrfs_pkg::COLOR_W-1:0]  read_color;
  logic                          in_range;
  logic [lrfs_pkg::COUNT_W-1:0]  pixels_written;

  modport source (
    output valid, read_color, in_range, pixels_written,
    input  ready
  );
  modport sink (
    input  valid, read_color, in_range, pixels_written,
    output ready
  );
endinterface

/* sv/lrfs_front.sv */
// Front end: accepts command items and classifies lines into a major-axis walk.
// Depends on lrfs_pkg and lrfs_in_if.
module lrfs_front (
  lrfs_in_if.sink          in_i,
  input  logic             hold_i,
  input  logic             q_full_i,
  output logic             push_o,
  output lrfs_pkg::job_t   job_o
);

  lrfs_pkg::action_e               kind;
  lrfs_pkg::coord_t                sx, sy, ex, ey;
  logic signed [lrfs_pkg::DELTA_W-1:0] dx_raw, dy_raw;
  logic [lrfs_pkg::DELTA_W-1:0]    dx, dy;
  logic                            is_line, xm, swap;
  lrfs_pkg::coord_t                min_end;

  // Handshake: an item enters whenever the queue has room and the clearing pass after reset is done.
  assign in_i.ready = !q_full_i && !hold_i;
  assign push_o     = in_i.valid && in_i.ready;

  assign kind = lrfs_pkg::action_e'(in_i.action);
  assign sx   = in_i.start_x;
  assign sy   = in_i.start_y;
  assign ex   = in_i.end_x;
  assign ey   = in_i.end_y;

  // Absolute deltas of both axes.
  always_comb begin
    dx_raw = {sx[lrfs_pkg::COORD_W-1], sx} - {ex[lrfs_pkg::COORD_W-1], ex};
    dy_raw = {sy[lrfs_pkg::COORD_W-1], sy} - {ey[lrfs_pkg::COORD_W-1], ey};
    dx     = dx_raw[lrfs_pkg::DELTA_W-1] ? -dx_raw : dx_raw;
    dy     = dy_raw[lrfs_pkg::DELTA_W-1] ? -dy_raw : dy_raw;
  end

  // Pick the major axis (ties go to y) and walk it from its lower end.
  always_comb begin
    is_line = (kind == lrfs_pkg::ACT_LINE);
    xm      = is_line ? (dx > dy) : 1'b1;
    swap    = is_line && (xm ? (ex < sx) : (ey < sy));

    job_o.kind  = kind;
    job_o.color = in_i.pixel_color;
    job_o.x_major = xm;
    if (xm) begin
      job_o.maj_start = swap ? ex : sx;
      job_o.maj_end   = swap ? sx : ex;
      job_o.min_start = swap ? ey : sy;
      min_end         = swap ? sy : ey;
      job_o.dmaj      = dx;
      job_o.dmin      = dy;
    end else begin
      job_o.maj_start = swap ? ey : sy;
      job_o.maj_end   = swap ? sy : ey;
      job_o.min_start = swap ? ex : sx;
      min_end         = swap ? sx : ex;
      job_o.dmaj      = dy;
      job_o.dmin      = dx;
    end
    job_o.step_neg = !(job_o.min_start < min_end);
  end

endmodule

/* sv/lrfs_queue.sv */
// Short command queue between the front end and the back end.
// Depends on lrfs_pkg for the descriptor type and depth.
module lrfs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lrfs_pkg::job_t  job_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output lrfs_pkg::job_t  job_o
);

  lrfs_pkg::job_t                   slot_q [lrfs_pkg::QUEUE_DEPTH];
  logic [lrfs_pkg::QPTR_W-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lrfs_pkg::QPTR_W:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (lrfs_pkg::QPTR_W+1)'(lrfs_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= job_i;
    end
  end

endmodule

/* sv/lrfs_back.sv */
// Back end: executes commands against the frame store memory and returns results.
// Depends on lrfs_pkg and lrfs_out_if.
module lrfs_back #(
  parameter int unsigned MAX_WIDTH  = lrfs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lrfs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lrfs_pkg::CFG_W-1:0]  active_width_i,
  input  logic [lrfs_pkg::CFG_W-1:0]  active_height_i,
  input  logic                        job_valid_i,
  input  lrfs_pkg::job_t              job_i,
  output logic                        job_pop_o,
  output logic                        init_busy_o,
  lrfs_out_if.source                  out_o
);

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned ADDR_W = XW + YW;
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PLOT  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;
  localparam logic [2:0] S_LINE  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]                       state_q, state_d;
  logic [ADDR_W-1:0]                clr_addr_q, clr_addr_d;
  logic                             clr_cmd_q, clr_cmd_d;
  logic                             init_q, init_d;
  logic                             out_valid_q, out_valid_d;

  // Working copy of the current command and walk state.
  lrfs_pkg::job_t                   job_q;
  lrfs_pkg::coord_t                 maj_q, min_q;
  logic [lrfs_pkg::DELTA_W-1:0]     acc_q;
  logic                             phase_q;
  logic [lrfs_pkg::COLOR_W-1:0]     res_color_q;
  logic                             res_inr_q;
  logic [lrfs_pkg::COUNT_W-1:0]     cnt_q;
  logic [lrfs_pkg::COLOR_W-1:0]     out_color_q;
  logic                             out_inr_q;
  logic [lrfs_pkg::COUNT_W-1:0]     out_cnt_q;

  logic [lrfs_pkg::COLOR_W-1:0]     mem_q [DEPTH];
  logic [lrfs_pkg::COLOR_W-1:0]     rdata_q;

  logic [lrfs_pkg::DIM_W-1:0]       eff_w, eff_h;
  lrfs_pkg::coord_t                 px, py, pxm1, pym1;
  logic                             in_area;
  logic [ADDR_W-1:0]                pix_addr;
  logic                             mem_we;
  logic [ADDR_W-1:0]                mem_waddr;
  logic [lrfs_pkg::COLOR_W-1:0]     mem_wdata;
  logic [lrfs_pkg::DELTA_W:0]       acc_sum, acc_diff;
  logic                             dbl, last, resp_take;

  assign init_busy_o = init_q;
  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign resp_take   = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  assign out_o.valid          = out_valid_q;
  assign out_o.read_color     = out_color_q;
  assign out_o.in_range       = out_inr_q;
  assign out_o.pixels_written = out_cnt_q;

  // Active area, limited to the store size.
  always_comb begin
    eff_w = ({2'b00, active_width_i} > lrfs_pkg::DIM_W'(MAX_WIDTH)) ?
            lrfs_pkg::DIM_W'(MAX_WIDTH) : {2'b00, active_width_i};
    eff_h = ({2'b00, active_height_i} > lrfs_pkg::DIM_W'(MAX_HEIGHT)) ?
            lrfs_pkg::DIM_W'(MAX_HEIGHT) : {2'b00, active_height_i};
  end

  // Current pixel, clip test and store address.
  always_comb begin
    px     = job_q.x_major ? maj_q : min_q;
    py     = job_q.x_major ? min_q : maj_q;
    in_area = !px[lrfs_pkg::COORD_W-1] && (px != '0) && ({1'b0, px} <= eff_w) &&
              !py[lrfs_pkg::COORD_W-1] && (py != '0) && ({1'b0, py} <= eff_h);
    pxm1     = px - 1'b1;
    pym1     = py - 1'b1;
    pix_addr = {pym1[YW-1:0], pxm1[XW-1:0]};
  end

  // Line stepping: accumulate the minor delta and check for a minor step.
  always_comb begin
    acc_sum  = {1'b0, acc_q} + {1'b0, job_q.dmin};
    acc_diff = acc_sum - {1'b0, job_q.dmaj};
    dbl      = !acc_diff[lrfs_pkg::DELTA_W] && (job_q.dmin != '0);
    last     = (maj_q == job_q.maj_end);
  end

  // Single write port of the store.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = job_q.color;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
      end
      S_PLOT, S_LINE: begin
        mem_we = in_area;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[pix_addr];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    clr_cmd_d   = clr_cmd_q;
    init_d      = init_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          init_d  = 1'b0;
          state_d = clr_cmd_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid_i) begin
          case (job_i.kind)
            lrfs_pkg::ACT_PLOT: state_d = S_PLOT;
            lrfs_pkg::ACT_LINE: state_d = S_LINE;
            lrfs_pkg::ACT_READ: state_d = S_READ;
            default: begin
              state_d    = S_CLEAR;
              clr_addr_d = '0;
              clr_cmd_d  = 1'b1;
            end
          endcase
        end
      end
      S_PLOT:  state_d = S_RESP;
      S_READ:  state_d = S_RWAIT;
      S_RWAIT: state_d = S_RESP;
      S_LINE: begin
        if ((!phase_q && !dbl || phase_q) && last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (resp_take) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      clr_cmd_q   <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_cmd_q   <= clr_cmd_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command datapath: walk registers and result registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_q       <= job_i;
          maj_q       <= job_i.maj_start;
          min_q       <= job_i.min_start;
          acc_q       <= '0;
          phase_q     <= 1'b0;
          res_color_q <= '0;
          res_inr_q   <= 1'b0;
          cnt_q       <= '0;
        end
      end
      S_PLOT: begin
        res_inr_q <= in_area;
        cnt_q     <= lrfs_pkg::COUNT_W'(in_area);
      end
      S_READ: begin
        res_inr_q <= in_area;
      end
      S_RWAIT: begin
        res_color_q <= res_inr_q ? rdata_q : '0;
      end
      S_LINE: begin
        if (in_area) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (!phase_q && dbl) begin
          acc_q   <= acc_diff[lrfs_pkg::DELTA_W-1:0];
          min_q   <= min_q + {{(lrfs_pkg::COORD_W-1){job_q.step_neg}}, 1'b1};
          phase_q <= 1'b1;
        end else begin
          if (!phase_q) begin
            acc_q <= acc_sum[lrfs_pkg::DELTA_W-1:0];
          end
          phase_q <= 1'b0;
          if (!last) begin
            maj_q <= maj_q + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (resp_take) begin
          out_color_q <= res_color_q;
          out_inr_q   <= res_inr_q;
          out_cnt_q   <= cnt_q;
        end
      end
      default: begin
        res_color_q <= res_color_q;
      end
    endcase
  end

endmodule

/* sv/line_raster_frame_store_top.sv */
// Top level of the line raster frame store: configuration registers, front end,
// command queue and back end. Depends on lrfs_pkg, lrfs_if, lrfs_front, lrfs_queue, lrfs_back.
//
// Each command item yields one result item. A line makes one store access per walk step, that is
// (major length + 1) plus one per minor step; all accesses go through the back end's
// single store write port. A clear sweeps the whole store one word per cycle:
// 2**(clog2(MAX_WIDTH) + clog2(MAX_HEIGHT)) words, 262144 at the default size. After reset
// the same clearing pass runs before the first item is accepted. Configuration writes
// are taken at any time and must only be made while no command is in flight.
module line_raster_frame_store_top #(
  parameter int unsigned MAX_WIDTH  = lrfs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lrfs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lrfs_pkg::CFG_W-1:0]      cfg_wdata_i,
  lrfs_in_if.sink                         in_i,
  lrfs_out_if.source                      out_o
);

  logic [lrfs_pkg::CFG_W-1:0] active_width_q, active_height_q;
  logic                       push, q_full, q_valid, pop, init_busy;
  lrfs_pkg::job_t             front_job, queue_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_width_q  <= lrfs_pkg::ACTIVE_RESET;
      active_height_q <= lrfs_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lrfs_pkg::REG_ACTIVE_WIDTH:  active_width_q  <= cfg_wdata_i;
        lrfs_pkg::REG_ACTIVE_HEIGHT: active_height_q <= cfg_wdata_i;
        default: active_width_q <= active_width_q;
      endcase
    end
  end

  lrfs_front u_front (
    .in_i     (in_i),
    .hold_i   (init_busy),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (front_job)
  );

  lrfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .job_o   (queue_job)
  );

  lrfs_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .active_width_i  (active_width_q),
    .active_height_i (active_height_q),
    .job_valid_i     (q_valid),
    .job_i           (queue_job),
    .job_pop_o       (pop),
    .init_busy_o     (init_busy),
    .out_o           (out_o)
  );

endmodule
